FILE: rtl/core/motor_stall_detect_move_top_assert.svh
// Assertion macros for the motor stall detector.
// Clocked on aclk, disabled while aresetn is low; define ASSERT_OFF to drop them.
`ifndef MOTOR_STALL_DETECT_MOVE_TOP_ASSERT_SVH
`define MOTOR_STALL_DETECT_MOVE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define MSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("motor stall detector: same-cycle check failed");

// Next-cycle implication
`define MSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("motor stall detector: next-cycle check failed");

`else

`define MSD_ASSERT_IMP(lbl, ante, cons)
`define MSD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/msd_pkg.sv
// Shared types and constants for the motor stall detector.
// No dependencies; used by msd_step and motor_stall_detect_move_top.
package msd_pkg;

    // Run phase, also the status code of a result word
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_STARTUP = 3'd1,
        PH_RUN     = 3'd2,
        PH_STALL   = 3'd3,
        PH_TIMEOUT = 3'd4,
        PH_EXTSTOP = 3'd5
    } msd_phase_t;

    // Input word function codes
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_EDGE  = 2'd1,
        FUNC_START = 2'd2,
        FUNC_STOP  = 2'd3
    } msd_func_t;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_MIN_PULSES = 2'd0;
    localparam logic [1:0] REG_TIMEOUT    = 2'd1;
    localparam logic [1:0] REG_STARTUP    = 2'd2;
    localparam logic [1:0] REG_SAMPLE     = 2'd3;

    localparam int ADDR_W = 4;

    // Register reset values
    localparam logic [15:0] MIN_PULSES_RST = 16'd1;
    localparam logic [19:0] TIMEOUT_RST    = 20'd5000;
    localparam logic [11:0] STARTUP_RST    = 12'd500;
    localparam logic [11:0] SAMPLE_RST     = 12'd100;

    // Elapsed-time saturation value
    localparam logic [19:0] MS_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [15:0] min_pulses;
        logic [19:0] timeout_ms;
        logic [11:0] startup_ms;
        logic [11:0] sample_ms;
    } msd_cfg_t;

    typedef struct packed {
        logic [31:0]        pos;
        msd_phase_t         phase;
        logic [19:0]        elapsed;
        logic [19:0]        last_ms;
        logic [31:0]        last_pos;
        logic signed [8:0]  drive;
    } msd_state_t;

endpackage

FILE: rtl/core/msd_step.sv
// Next-state logic of the stall detector: one input word against the run state.
// Depends on msd_pkg for the state, configuration, phase and function types.
module msd_step (
    input  msd_pkg::msd_state_t  st_cur,
    input  msd_pkg::msd_cfg_t    cfg,
    input  msd_pkg::msd_func_t   func,
    input  logic                 phase_b,
    input  logic signed [8:0]    start_power,
    output msd_pkg::msd_state_t  st_next,
    output logic                 done
);

    logic        run_chk;
    logic [19:0] elapsed_inc;
    logic [19:0] since_chk;
    logic [31:0] diff;
    logic [31:0] mag;

    assign elapsed_inc = (st_cur.elapsed == msd_pkg::MS_MAX) ? st_cur.elapsed
                                                             : st_cur.elapsed + 20'd1;

    // Apply the word, then run the stop checks on the updated state
    always_comb begin
        st_next   = st_cur;
        done      = 1'b0;
        run_chk   = 1'b0;
        since_chk = 20'd0;
        diff      = 32'd0;
        mag       = 32'd0;

        case (func)
            msd_pkg::FUNC_TICK: begin
                if (st_cur.phase == msd_pkg::PH_STARTUP || st_cur.phase == msd_pkg::PH_RUN) begin
                    st_next.elapsed = elapsed_inc;
                    if (st_cur.phase == msd_pkg::PH_STARTUP &&
                        elapsed_inc >= {8'd0, cfg.startup_ms}) begin
                        st_next.phase = msd_pkg::PH_RUN;
                    end
                    run_chk = (st_next.phase == msd_pkg::PH_RUN);
                end
            end
            msd_pkg::FUNC_EDGE: begin
                st_next.pos = phase_b ? st_cur.pos + 32'd1 : st_cur.pos - 32'd1;
            end
            msd_pkg::FUNC_START: begin
                st_next.drive    = start_power;
                st_next.elapsed  = 20'd0;
                st_next.last_ms  = 20'd0;
                st_next.last_pos = st_cur.pos;
                if (cfg.startup_ms == 12'd0) begin
                    st_next.phase = msd_pkg::PH_RUN;
                    run_chk       = 1'b1;
                end else begin
                    st_next.phase = msd_pkg::PH_STARTUP;
                end
            end
            msd_pkg::FUNC_STOP: begin
                if (st_cur.phase == msd_pkg::PH_RUN) begin
                    st_next.phase = msd_pkg::PH_EXTSTOP;
                    st_next.drive = 9'sd0;
                    done          = 1'b1;
                end
            end
            default: begin
                st_next = st_cur;
            end
        endcase

        // Timeout first, then the stall check once a sample period has passed
        if (run_chk) begin
            since_chk = st_next.elapsed - st_next.last_ms;
            diff      = st_next.pos - st_next.last_pos;
            mag       = diff[31] ? (~diff + 32'd1) : diff;
            if (st_next.elapsed >= cfg.timeout_ms) begin
                st_next.phase = msd_pkg::PH_TIMEOUT;
                st_next.drive = 9'sd0;
                done          = 1'b1;
            end else if (since_chk > {8'd0, cfg.sample_ms}) begin
                if (mag < {16'd0, cfg.min_pulses}) begin
                    st_next.phase = msd_pkg::PH_STALL;
                    st_next.drive = 9'sd0;
                    done          = 1'b1;
                end else begin
                    st_next.last_pos = st_next.pos;
                    st_next.last_ms  = st_next.elapsed;
                end
            end
        end
    end

endmodule

FILE: rtl/core/motor_stall_detect_move_top.sv
// Motor stall detector top level: handshake stages, run state and APB registers.
// Depends on msd_pkg, msd_step and motor_stall_detect_move_top_assert.svh.
//
// Takes one word per cycle on the s_ channel (millisecond tick, encoder edge,
// start, stop) while s_ready is high, and returns one result word per input on
// the m_ channel. The result is registered and is taken when m_ready is high.
// Sustained rate is one word per clock while m_ready stays high: the input
// register feeds a single combinational update of the run state (one 32-bit
// subtract and compare for the stall check), written into the state and result
// registers together. The result register lets the next word enter while a
// result waits for m_ready. Registers sit at byte addresses 0 (minimum pulses
// per sample), 4 (timeout ms), 8 (startup ms), 12 (sample ms) and are to be
// written only while no word is in flight.
`include "motor_stall_detect_move_top_assert.svh"

module motor_stall_detect_move_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_func,
    input  logic                          s_phase_b,
    input  logic signed [8:0]             s_start_power,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [8:0]             m_motor_drive,
    output logic [2:0]                    m_status,
    output logic signed [31:0]            m_pulse_count,
    output logic                          m_done_res,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msd_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    msd_pkg::msd_cfg_t   cfg_reg, cfg_next;
    msd_pkg::msd_state_t st_reg, st_next;
    msd_pkg::msd_func_t  func_reg;
    logic                phase_b_reg;
    logic signed [8:0]   power_reg;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [8:0]   out_drive_reg;
    msd_pkg::msd_phase_t out_status_reg;
    logic [31:0]         out_pos_reg;
    logic                out_done_reg;
    logic                step_done;
    logic                advance;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;
    logic                st_ended;
    logic                res_ended;

    // Handshake: the input stage moves on when the result stage is free or its word is taken
    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || !out_valid_reg || m_ready;
    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg    <= msd_pkg::msd_func_t'(s_func);
            phase_b_reg <= s_phase_b;
            power_reg   <= s_start_power;
        end
    end

    msd_step u_step (
        .st_cur      (st_reg),
        .cfg         (cfg_reg),
        .func        (func_reg),
        .phase_b     (phase_b_reg),
        .start_power (power_reg),
        .st_next     (st_next),
        .done        (step_done)
    );

    // Hold state and valids; advance state on each processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            st_reg.pos      <= 32'd0;
            st_reg.phase    <= msd_pkg::PH_IDLE;
            st_reg.elapsed  <= 20'd0;
            st_reg.last_ms  <= 20'd0;
            st_reg.last_pos <= 32'd0;
            st_reg.drive    <= 9'sd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg  <= st_next.drive;
            out_status_reg <= st_next.phase;
            out_pos_reg    <= st_next.pos;
            out_done_reg   <= step_done;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_motor_drive = out_drive_reg;
    assign m_status      = out_status_reg;
    assign m_pulse_count = out_pos_reg;
    assign m_done_res    = out_done_reg;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                msd_pkg::REG_MIN_PULSES: cfg_next.min_pulses = pwdata[15:0];
                msd_pkg::REG_TIMEOUT:    cfg_next.timeout_ms = pwdata[19:0];
                msd_pkg::REG_STARTUP:    cfg_next.startup_ms = pwdata[11:0];
                msd_pkg::REG_SAMPLE:     cfg_next.sample_ms  = pwdata[11:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pulses <= msd_pkg::MIN_PULSES_RST;
            cfg_reg.timeout_ms <= msd_pkg::TIMEOUT_RST;
            cfg_reg.startup_ms <= msd_pkg::STARTUP_RST;
            cfg_reg.sample_ms  <= msd_pkg::SAMPLE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb begin
        case (cfg_idx)
            msd_pkg::REG_MIN_PULSES: prdata = {16'd0, cfg_reg.min_pulses};
            msd_pkg::REG_TIMEOUT:    prdata = {12'd0, cfg_reg.timeout_ms};
            msd_pkg::REG_STARTUP:    prdata = {20'd0, cfg_reg.startup_ms};
            msd_pkg::REG_SAMPLE:     prdata = {20'd0, cfg_reg.sample_ms};
            default:                 prdata = 32'd0;
        endcase
    end

    // Ending phases of the run state and of the result word
    assign st_ended  = (st_reg.phase == msd_pkg::PH_STALL) ||
                       (st_reg.phase == msd_pkg::PH_TIMEOUT) ||
                       (st_reg.phase == msd_pkg::PH_EXTSTOP);
    assign res_ended = (m_status == 3'(msd_pkg::PH_STALL)) ||
                       (m_status == 3'(msd_pkg::PH_TIMEOUT)) ||
                       (m_status == 3'(msd_pkg::PH_EXTSTOP));

    // An ended run never drives the motor
    `MSD_ASSERT_IMP(a_ended_no_drive, st_ended, st_reg.drive == 9'sd0)
    // A done result always reports an ending status
    `MSD_ASSERT_IMP(a_done_ended, m_valid && m_done_res, res_ended)
    // A word held in the input stage is not dropped
    `MSD_ASSERT_NXT(a_in_hold, in_valid_reg && !advance, in_valid_reg)

endmodule
